/* hdl/ftoc_pkg.sv */
// Package for the flow-to-owner cache: operation codes, field widths, control structs.
// No dependencies.
`default_nettype none
package ftoc_pkg;
  localparam int OpW = 2;
  localparam int OwnerW = 23;
  localparam int TickW = 32;
  localparam int CfgW = 31;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_RESOLVED = 2'd1,
    OP_NEGATIVE = 2'd2,
    OP_EXISTS   = 2'd3
  } op_e;

  localparam logic [1:0] REG_TTL = 2'd0;
  localparam logic [1:0] REG_HOLD = 2'd1;
  localparam logic [1:0] REG_COOL = 2'd2;

  typedef struct packed {
    logic start;     // begin a sweep over all slots
    logic apply;     // apply operation to the found or chosen slot
    logic evict;     // drop the oldest slot
  } ftoc_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic apply_done;
  } ftoc_sts_t;

  function automatic logic tick_before(input logic [TickW-1:0] a, input logic [TickW-1:0] b);
    logic [TickW-1:0] d;
    d = a - b;
    return d[TickW-1];
  endfunction
endpackage
`default_nettype wire

/* hdl/ftoc_ctrl.sv */
// Controller of the flow-to-owner cache: sequences sweep, evict and apply steps.
// Depends on ftoc_pkg.
`default_nettype none
module ftoc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_taken_i,
  output logic                   out_valid_o,
  input  wire logic              need_evict_i,
  output ftoc_pkg::ftoc_cmd_t    cmd_o,
  input  wire ftoc_pkg::ftoc_sts_t sts_i
);
  import ftoc_pkg::*;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: if (sts_i.sweep_done) begin
        state_d = need_evict_i ? S_EVICT : S_APPLY;
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.apply_done) state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

/* hdl/ftoc_dp.sv */
// Datapath of the flow-to-owner cache: entry memories, slot sweep, result register.
// Depends on ftoc_pkg.
`default_nettype none
module ftoc_dp #(
  parameter int Entries = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ftoc_pkg::ftoc_cmd_t          cmd_i,
  output ftoc_pkg::ftoc_sts_t               sts_o,
  output logic                              need_evict_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [63:0]                  addrs_i,
  input  wire logic [39:0]                  ppp_i,
  input  wire logic [ftoc_pkg::OwnerW-1:0]  owner_i,
  input  wire logic [ftoc_pkg::TickW-1:0]   now_i,
  input  wire logic [ftoc_pkg::CfgW-1:0]    ttl_i,
  input  wire logic [ftoc_pkg::CfgW-1:0]    hold_i,
  input  wire logic [ftoc_pkg::CfgW-1:0]    cool_i,
  output logic [ftoc_pkg::OwnerW-1:0]       owner_o,
  output logic                              scan_o,
  output logic                              present_o
);
  import ftoc_pkg::*;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  // memories: one row per slot
  logic [63:0]        m_addrs [Entries];
  logic [39:0]        m_ppp   [Entries];
  logic [OwnerW-1:0]  m_owner [Entries];
  logic [TickW-1:0]   m_seen  [Entries];
  logic [TickW-1:0]   m_scan  [Entries];
  logic [1:0]         m_marks [Entries];
  logic [Entries-1:0] valid_q;

  logic [1:0]       op_q;
  logic [63:0]      addrs_q;
  logic [39:0]      ppp_q;
  logic [OwnerW-1:0] own_q;
  logic [TickW-1:0] now_q;
  logic             busy_q, rd_v_q, done_q;
  logic [IdxW:0]    rd_idx_q;
  logic [IdxW-1:0]  p_idx_q;
  logic [63:0]      r_addrs_q;
  logic [39:0]      r_ppp_q;
  logic [TickW-1:0] r_seen_q;
  logic             found_q, have_free_q, have_old_q;
  logic [IdxW-1:0]  found_idx_q, free_idx_q, old_idx_q;
  logic [TickW-1:0] old_seen_q;
  logic [CntW-1:0]  cnt_q;
  logic [1:0]       aph_q;
  logic [OwnerW-1:0] a_owner_q;
  logic [TickW-1:0]  a_scan_q;
  logic [1:0]        a_marks_q;

  logic pv, stale, live, rd_end;
  assign rd_end = rd_idx_q == (IdxW+1)'(Entries);
  assign pv = valid_q[p_idx_q];
  assign stale = tick_before(r_seen_q + {1'b0, ttl_i}, now_q);
  assign live = rd_v_q && pv && !stale;
  assign need_evict_o = !found_q && (op_q == OP_LOOKUP || op_q == OP_RESOLVED)
                        && cnt_q == CntW'(Entries);
  assign sts_o.sweep_done = done_q;
  assign sts_o.apply_done = aph_q == 2'd2;

  logic [TickW-1:0] nowp_hold, nowp_cool;
  assign nowp_hold = a_scan_q + {1'b0, hold_i};
  assign nowp_cool = a_scan_q + {1'b0, cool_i};

  logic              scan_ok, scan_d;
  logic [OwnerW-1:0] owner_d;
  assign scan_ok = a_owner_q == '0 && !(a_marks_q[1] && tick_before(now_q, nowp_hold))
                   && !a_marks_q[0] && !tick_before(now_q, nowp_cool);

  always_comb begin
    owner_d = '0;
    scan_d = 1'b0;
    if (op_q == OP_LOOKUP) begin
      if (!found_q) scan_d = 1'b1;
      else if (a_owner_q != '0) owner_d = a_owner_q;
      else scan_d = scan_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= op_i; addrs_q <= addrs_i; ppp_q <= ppp_i; own_q <= owner_i; now_q <= now_i;
    end
    if (busy_q && !rd_end) begin
      r_addrs_q <= m_addrs[rd_idx_q[IdxW-1:0]];
      r_ppp_q <= m_ppp[rd_idx_q[IdxW-1:0]];
      r_seen_q <= m_seen[rd_idx_q[IdxW-1:0]];
      p_idx_q <= rd_idx_q[IdxW-1:0];
    end
    if (live && (!have_old_q || tick_before(r_seen_q, old_seen_q))) begin
      old_idx_q <= p_idx_q; old_seen_q <= r_seen_q;
    end
    if (live && !found_q && r_addrs_q == addrs_q && r_ppp_q == ppp_q) found_idx_q <= p_idx_q;
    if (cmd_i.apply && aph_q == 2'd0) begin
      a_owner_q <= m_owner[found_idx_q];
      a_scan_q <= m_scan[found_idx_q];
      a_marks_q <= m_marks[found_idx_q];
    end
    if (cmd_i.apply && aph_q == 2'd1) begin
      if (found_q) begin
        case (op_q)
          OP_LOOKUP: begin
            m_seen[found_idx_q] <= now_q;
            if (a_owner_q == '0 && !(a_marks_q[1] && tick_before(now_q, nowp_hold))
                && !a_marks_q[0] && !tick_before(now_q, nowp_cool)) begin
              m_marks[found_idx_q] <= a_marks_q | 2'b01;
              m_scan[found_idx_q] <= now_q;
            end
          end
          OP_RESOLVED: begin
            m_owner[found_idx_q] <= own_q;
            m_seen[found_idx_q] <= now_q;
            m_marks[found_idx_q] <= 2'b00;
          end
          OP_NEGATIVE: begin
            m_owner[found_idx_q] <= '0;
            m_marks[found_idx_q] <= 2'b10;
            m_scan[found_idx_q] <= now_q;
          end
          default: ;
        endcase
      end else if (op_q == OP_LOOKUP || op_q == OP_RESOLVED) begin
        m_addrs[free_idx_q] <= addrs_q;
        m_ppp[free_idx_q] <= ppp_q;
        m_owner[free_idx_q] <= (op_q == OP_LOOKUP) ? '0 : own_q;
        m_seen[free_idx_q] <= now_q;
        m_scan[free_idx_q] <= now_q;
        m_marks[free_idx_q] <= (op_q == OP_LOOKUP) ? 2'b01 : 2'b00;
      end
      present_o <= found_q;
      owner_o <= owner_d;
      scan_o <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; cnt_q <= '0; busy_q <= 1'b0; rd_v_q <= 1'b0; done_q <= 1'b0;
      rd_idx_q <= '0; found_q <= 1'b0; have_free_q <= 1'b0; have_old_q <= 1'b0;
      free_idx_q <= '0; aph_q <= '0;
    end else begin
      done_q <= busy_q && rd_end && !rd_v_q;
      if (cmd_i.start) begin
        busy_q <= 1'b1; rd_idx_q <= '0; found_q <= 1'b0;
        have_free_q <= 1'b0; have_old_q <= 1'b0;
      end
      rd_v_q <= busy_q && !rd_end;
      if (busy_q) begin
        if (rd_end) begin
          if (!rd_v_q) busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      if (rd_v_q) begin
        if (pv && stale) begin
          valid_q[p_idx_q] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
        end
        if (live) begin
          have_old_q <= 1'b1;
          if (!found_q && r_addrs_q == addrs_q && r_ppp_q == ppp_q) found_q <= 1'b1;
        end else if (!have_free_q) begin
          have_free_q <= 1'b1; free_idx_q <= p_idx_q;
        end
      end
      if (cmd_i.evict) begin
        valid_q[old_idx_q] <= 1'b0;
        cnt_q <= cnt_q - 1'b1;
        free_idx_q <= old_idx_q;
      end
      if (cmd_i.apply) begin
        aph_q <= (aph_q == 2'd2) ? 2'd0 : aph_q + 1'b1;
        if (aph_q == 2'd1 && !found_q && (op_q == OP_LOOKUP || op_q == OP_RESOLVED)) begin
          valid_q[free_idx_q] <= 1'b1;
          cnt_q <= cnt_q + (cmd_i.evict ? 1'b0 : 1'b1);
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/flow_to_owner_cache.sv */
// Flow-to-owner cache top level: stream ports, APB registers, controller and datapath.
// A word passes the sweep over the memories, one slot per cycle, then an evict step when a
// full table must make room, then the apply steps; the result word waits until it is taken.
// A new word is accepted only after the result word of the last one has been taken.
// Reset empties the table and loads register defaults; no clearing pass.
// Depends on ftoc_pkg, ftoc_ctrl, ftoc_dp.
`default_nettype none
module flow_to_owner_cache #(
  parameter int Entries = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // op[1:0], src_ip[33:2], dest_ip[65:34], sport[81:66], dport[97:82],
  // protocol[105:98], owner_id[128:106], now[160:129], zero fill to 168
  input  wire logic [167:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // owner_out[22:0], scan_request[23], present[24], zero fill to 32
  output logic [31:0]       m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ftoc_pkg::*;
  logic [CfgW-1:0] ttl_q, hold_q, cool_q;
  ftoc_cmd_t cmd;
  ftoc_sts_t sts;
  logic need_evict, scan, present;
  logic [OwnerW-1:0] owner;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= CfgW'(120000); hold_q <= CfgW'(2000); cool_q <= CfgW'(500);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TTL:  ttl_q <= pwdata[CfgW-1:0];
        REG_HOLD: hold_q <= pwdata[CfgW-1:0];
        REG_COOL: cool_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_TTL:  prdata = {1'b0, ttl_q};
      REG_HOLD: prdata = {1'b0, hold_q};
      REG_COOL: prdata = {1'b0, cool_q};
      default:  prdata = '0;
    endcase
  end

  ftoc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .out_taken_i(m_axis_tready_i), .out_valid_o(m_axis_tvalid_o),
    .need_evict_i(need_evict), .cmd_o(cmd), .sts_i(sts)
  );

  ftoc_dp #(.Entries(Entries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .need_evict_o(need_evict),
    .op_i(s_axis_tdata_i[1:0]),
    .addrs_i({s_axis_tdata_i[33:2], s_axis_tdata_i[65:34]}),
    .ppp_i({s_axis_tdata_i[81:66], s_axis_tdata_i[97:82], s_axis_tdata_i[105:98]}),
    .owner_i(s_axis_tdata_i[128:106]), .now_i(s_axis_tdata_i[160:129]),
    .ttl_i(ttl_q), .hold_i(hold_q), .cool_i(cool_q),
    .owner_o(owner), .scan_o(scan), .present_o(present)
  );

  assign m_axis_tdata_o = {7'd0, present, scan, owner};
endmodule
`default_nettype wire

/* sim/flow_to_owner_cache_tb.sv */
// Testbench for flow_to_owner_cache: drives request words over the stream port, holds a
// table predictor of its own and compares every result word field by field.
// Depends on ftoc_pkg and the flow_to_owner_cache RTL.
`timescale 1ns / 100ps
module flow_to_owner_cache_tb;
  import ftoc_pkg::*;

  localparam int Slots = 256;

  typedef struct packed {
    logic [22:0] owner;
    logic        scan;
    logic        present;
  } reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // op, src_ip, dest_ip, sport, dport, protocol, owner_id, now, zero fill
  logic [167:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // owner_out, scan_request, present, zero fill
  logic [31:0]  m_axis_tdata_o;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  flow_to_owner_cache dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [30:0] ttl_q, hold_q, cool_q;
  bit          slot_used[Slots];
  logic [63:0] slot_addrs[Slots];
  logic [39:0] slot_ppp[Slots];
  logic [22:0] slot_owner[Slots];
  logic [31:0] slot_seen[Slots];
  logic [31:0] slot_scan[Slots];
  logic [1:0]  slot_marks[Slots];
  int          slot_count;

  reply_t      replies_due[$];
  int          errors = 0;
  int          send_idle = 0, recv_idle = 0;
  bit          recv_hold = 1'b0;
  logic [31:0] clock_now = 32'd1000;

  function automatic bit older(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  task automatic place_flow(logic [63:0] a, logic [39:0] p, logic [22:0] own,
                            logic [31:0] t, logic [1:0] mk);
    int pick;
    bit have;
    have = 0;
    pick = 0;
    if (slot_count >= Slots) begin
      for (int i = 0; i < Slots; i++)
        if (slot_used[i] && (!have || older(slot_seen[i], slot_seen[pick]))) begin
          pick = i;
          have = 1;
        end
      if (have) begin
        slot_used[pick] = 0;
        slot_count--;
      end
    end
    for (int i = 0; i < Slots; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1;
        slot_addrs[i] = a;
        slot_ppp[i] = p;
        slot_owner[i] = own;
        slot_seen[i] = t;
        slot_scan[i] = t;
        slot_marks[i] = mk;
        slot_count++;
        return;
      end
  endtask

  task automatic predict_owner(op_e op, logic [31:0] sip, logic [31:0] dip,
                               logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                               logic [22:0] own, logic [31:0] t);
    logic [63:0] a;
    logic [39:0] p;
    reply_t r;
    int s;
    a = {sip, dip};
    p = {sp, dp, pr};
    r = '0;
    s = -1;
    for (int i = 0; i < Slots; i++)
      if (slot_used[i] && older(slot_seen[i] + {1'b0, ttl_q}, t)) begin
        slot_used[i] = 0;
        slot_count--;
      end
    for (int i = 0; i < Slots; i++)
      if (s < 0 && slot_used[i] && slot_addrs[i] == a && slot_ppp[i] == p) s = i;
    r.present = (s >= 0);
    case (op)
      OP_LOOKUP: begin
        if (s >= 0) begin
          slot_seen[s] = t;
          if (slot_owner[s] != 0) r.owner = slot_owner[s];
          else if (slot_marks[s][1] && older(t, slot_scan[s] + {1'b0, hold_q})) ;
          else if (slot_marks[s][0]) ;
          else if (older(t, slot_scan[s] + {1'b0, cool_q})) ;
          else begin
            slot_marks[s][0] = 1'b1;
            slot_scan[s] = t;
            r.scan = 1'b1;
          end
        end else begin
          place_flow(a, p, '0, t, 2'b01);
          r.scan = 1'b1;
        end
      end
      OP_RESOLVED: begin
        if (s >= 0) begin
          slot_owner[s] = own;
          slot_seen[s] = t;
          slot_marks[s] = 2'b00;
        end else place_flow(a, p, own, t, 2'b00);
      end
      OP_NEGATIVE: begin
        if (s >= 0) begin
          slot_owner[s] = '0;
          slot_marks[s] = 2'b10;
          slot_scan[s] = t;
        end
      end
      default: ;
    endcase
    replies_due.push_back(r);
  endtask

  task automatic send_word(op_e op, logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                           logic [15:0] dp, logic [7:0] pr, logic [22:0] own,
                           logic [31:0] t);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, t, own, pr, dp, sp, dip, sip, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_owner(op, sip, dip, sp, dp, pr, own, t);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {1'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TTL:  ttl_q = val;
      REG_HOLD: hold_q = val;
      default:  cool_q = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (Slots + 20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= !recv_hold && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        reply_t e;
        e = replies_due.pop_front();
        if (m_axis_tdata_o[22:0] !== e.owner || m_axis_tdata_o[23] !== e.scan ||
            m_axis_tdata_o[24] !== e.present || m_axis_tdata_o[31:25] !== 7'd0) begin
          $display("%0t: expected owner %h scan %b present %b, got %h", $time,
                   e.owner, e.scan, e.present, m_axis_tdata_o);
          errors++;
        end
      end
    end
  end

  // small key space so flows repeat
  task automatic random_word(int key_span, int step_max);
    int k;
    k = $urandom_range(key_span);
    clock_now = clock_now + $urandom_range(step_max);
    send_word(op_e'($urandom_range(3)), 32'h0a00_0000 + k, 32'hc0a8_0001 ^ (k * 7),
              16'(k * 3), 16'(443 + k), 8'(k % 3 == 0 ? 17 : 6),
              ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom), clock_now);
  endtask

  task automatic test_directed();
    logic [31:0] t;
    t = 32'd100;
    send_word(OP_EXISTS, '1, '1, '1, '1, '1, '1, t);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t + 1);
    send_word(OP_NEGATIVE, '0, '0, '0, '0, '0, '0, t + 2);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t + 3);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t + 3000);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t + 3001);
    send_word(OP_RESOLVED, '0, '0, '0, '0, '0, 23'h7fffff, t + 3002);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, t + 3003);
    send_word(OP_RESOLVED, '1, '1, '1, '1, '1, 23'd1, t + 3004);
    send_word(OP_EXISTS, '1, '1, '1, '1, '1, '0, t + 3005);
    send_word(OP_NEGATIVE, 32'h1234, '0, '0, '0, '0, '0, t + 3006);
    send_word(OP_RESOLVED, '1, '1, '1, '1, '1, '0, t + 3007);
    send_word(OP_LOOKUP, '1, '1, '1, '1, '1, '0, t + 3600);
    send_word(OP_EXISTS, '0, '0, '0, '0, '0, '0, t + 200000);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 32'hffff_fff0);
    send_word(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 32'h0000_0010);
    send_word(OP_EXISTS, '0, '0, '0, '0, '0, '0, 32'h0000_0020);
    clock_now = 32'h20;
    drain();
  endtask

  task automatic test_eviction();
    for (int i = 0; i < Slots + 12; i++)
      send_word(op_e'(i % 2 ? OP_RESOLVED : OP_LOOKUP), 32'hac10_0000 + i, '0, 16'(i), 16'd80,
                8'd6, 23'(i), clock_now + (i % 5));
    clock_now = clock_now + 10;
    for (int i = 0; i < 12; i++)
      send_word(OP_EXISTS, 32'hac10_0000 + i, '0, 16'(i), 16'd80, 8'd6, '0, clock_now);
    drain();
  endtask

  task automatic test_random(int n, int span, int step);
    for (int i = 0; i < n; i++) random_word(span, step);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) random_word(40, 50);
    join
    drain();
  endtask

  initial begin
    ttl_q = 31'd120000;
    hold_q = 31'd2000;
    cool_q = 31'd500;
    slot_count = 0;
    for (int i = 0; i < Slots; i++) slot_used[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 21;
    recv_idle = 85;
    test_directed();
    test_eviction();
    test_random(350, 60, 300);
    write_reg(REG_TTL, 31'd1);
    write_reg(REG_HOLD, 31'd0);
    write_reg(REG_COOL, 31'd0);
    send_idle = 85;
    recv_idle = 21;
    test_random(350, 30, 2);
    write_reg(REG_TTL, 31'h7fffffff);
    write_reg(REG_HOLD, 31'h7fffffff);
    write_reg(REG_COOL, 31'h7fffffff);
    test_random(300, 400, 1 << 20);
    send_idle = 0;
    recv_idle = 0;
    test_backpressure();
    write_reg(REG_TTL, 31'd5000);
    write_reg(REG_HOLD, 31'd300);
    write_reg(REG_COOL, 31'd100);
    test_random(350, 50, 200);
    if (errors == 0) $display("flow_to_owner_cache regression: pass");
    else $display("flow_to_owner_cache regression: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("flow_to_owner_cache regression: fail");
    $finish;
  end
endmodule
